// ----- design/rasq_pkg.sv -----
package rasq_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;

  localparam int unsigned TYPE_W      = 3;
  localparam int unsigned POS_W       = 11;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned CNT_OUT_W   = 11;
  localparam int unsigned MOD_W       = 31;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [TYPE_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_ERASE  = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_CHANGE = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_READ   = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_RANGE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_OP_MODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 8'd1;

  typedef struct packed {
    logic load;
    logic check;
    logic scan_init;
    logic scan_issue;
    logic put;
    logic count_inc;
    logic count_dec;
    logic div_init;
    logic div_step;
    logic result;
  } rasq_cmd_t;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic              err;
    logic              need_shift;
    logic              scan_last;
    logic              div_last;
    logic              sum_mode;
    logic              out_free;
  } rasq_sts_t;

endpackage

// ----- design/rasq_datapath.sv -----
module rasq_datapath
  import rasq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  input  rasq_cmd_t              cmd_i,
  output rasq_sts_t              sts_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o,
  output logic                   out_err_o
);

  localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned ACC_W = VAL_W + CNT_W;
  localparam int unsigned DCW   = $clog2(ACC_W);

  logic [TYPE_W-1:0] type_q;
  logic [POS_W-1:0]  pos_q, rend_q;
  logic [VAL_W-1:0]  val_q;
  logic [CNT_W-1:0]  count_q;
  logic              op_mode_q;
  logic [MOD_W-1:0]  modulus_q;
  logic              err_q;
  logic [AW-1:0]     idx_q, stop_q, ra_q;
  logic              rv_q;
  logic [VAL_W-1:0]  rdata_q;
  logic [ACC_W-1:0]  acc_q, mag_q;
  logic              neg_q;
  logic [VAL_W-1:0]  rem_q;
  logic [DCW-1:0]    dcnt_q;
  logic              out_valid_q, out_err_q;
  logic [VAL_W-1:0]  out_res_q;
  logic [CNT_OUT_W-1:0] out_cnt_q;
  logic [VAL_W-1:0]  mem_q [CAPACITY];

  logic [31:0]       pos32, rend32, cnt32, cap32;
  logic [AW-1:0]     p0, idx_init, stop_init;
  logic              is_ins, is_era, is_rng, err_c, shift_c;
  logic [MOD_W-1:0]  m_eff;
  logic [VAL_W:0]    div_t, m33;
  logic [VAL_W-1:0]  rem_nx, rem_fix, res_c;
  logic [ACC_W-1:0]  acc_nx;
  logic              we;
  logic [AW-1:0]     wa;
  logic [VAL_W-1:0]  wd;

  assign pos32  = 32'(pos_q);
  assign rend32 = 32'(rend_q);
  assign cnt32  = 32'(count_q);
  assign cap32  = 32'(CAPACITY);
  assign p0     = AW'(pos32 - 32'd1);
  assign is_ins = (type_q == REQ_INSERT);
  assign is_era = (type_q == REQ_ERASE);
  assign is_rng = (type_q == REQ_RANGE);

  always_comb begin
    case (type_q)
      REQ_INSERT: err_c = (cnt32 >= cap32) || (pos32 == 32'd0) || (pos32 > cnt32 + 32'd1);
      REQ_ERASE,
      REQ_CHANGE,
      REQ_READ:   err_c = (pos32 == 32'd0) || (pos32 > cnt32);
      REQ_RANGE:  err_c = (pos32 == 32'd0) || (rend32 < pos32) || (rend32 > cnt32);
      default:    err_c = 1'b0;
    endcase
  end

  assign shift_c = is_ins ? (pos32 != cnt32 + 32'd1) : (pos32 != cnt32);

  always_comb begin
    case (type_q)
      REQ_INSERT: begin
        idx_init  = AW'(cnt32 - 32'd1);
        stop_init = p0;
      end
      REQ_ERASE: begin
        idx_init  = AW'(pos32);
        stop_init = AW'(cnt32 - 32'd1);
      end
      REQ_RANGE: begin
        idx_init  = p0;
        stop_init = AW'(rend32 - 32'd1);
      end
      default: begin
        idx_init  = p0;
        stop_init = p0;
      end
    endcase
  end

  // modulus of zero behaves as one
  assign m_eff  = (modulus_q == '0) ? MOD_W'(1) : modulus_q;
  assign m33    = {2'b00, m_eff};
  assign div_t  = {rem_q, mag_q[ACC_W-1]};
  assign rem_nx = (div_t >= m33) ? VAL_W'(div_t - m33) : div_t[VAL_W-1:0];
  assign rem_fix = (neg_q && rem_q != '0) ? ({1'b0, m_eff} - rem_q) : rem_q;

  assign acc_nx = op_mode_q ? (acc_q + {{(ACC_W-VAL_W){rdata_q[VAL_W-1]}}, rdata_q})
                            : (acc_q ^ {{(ACC_W-VAL_W){1'b0}}, rdata_q});

  always_comb begin
    if (err_q) begin
      res_c = '0;
    end else if (type_q == REQ_READ) begin
      res_c = rdata_q;
    end else if (is_rng) begin
      res_c = op_mode_q ? rem_fix : acc_q[VAL_W-1:0];
    end else begin
      res_c = '0;
    end
  end

  // one write port: value put, or the trailing write of a shift move
  assign we = cmd_i.put || (rv_q && (is_ins || is_era));
  assign wa = cmd_i.put ? p0 : (is_ins ? ra_q + AW'(1) : ra_q - AW'(1));
  assign wd = cmd_i.put ? val_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    // hold the last word read until the next scan
    if (cmd_i.scan_issue) begin
      rdata_q <= mem_q[idx_q];
      ra_q    <= idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      type_q <= in_data_i[TYPE_W-1:0];
      pos_q  <= in_data_i[TYPE_W+POS_W-1:TYPE_W];
      rend_q <= in_data_i[TYPE_W+2*POS_W-1:TYPE_W+POS_W];
      val_q  <= in_data_i[TYPE_W+2*POS_W+VAL_W-1:TYPE_W+2*POS_W];
    end
    if (cmd_i.scan_init) begin
      stop_q <= stop_init;
    end
    if (cmd_i.div_init) begin
      mag_q <= acc_q[ACC_W-1] ? (~acc_q + ACC_W'(1)) : acc_q;
      neg_q <= acc_q[ACC_W-1];
    end else if (cmd_i.div_step) begin
      mag_q <= {mag_q[ACC_W-2:0], 1'b0};
    end
    if (cmd_i.result) begin
      out_res_q <= res_c;
      out_cnt_q <= CNT_OUT_W'(count_q);
      out_err_q <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      op_mode_q   <= 1'b0;
      modulus_q   <= MOD_W'(1);
      err_q       <= 1'b0;
      idx_q       <= '0;
      rv_q        <= 1'b0;
      acc_q       <= '0;
      rem_q       <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_OP_MODE: op_mode_q <= cfg_data_i[0];
          REG_MODULUS: modulus_q <= cfg_data_i[MOD_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.check) begin
        err_q <= err_c;
      end
      if (cmd_i.scan_init) begin
        idx_q <= idx_init;
        acc_q <= '0;
      end else if (cmd_i.scan_issue) begin
        idx_q <= is_ins ? idx_q - AW'(1) : idx_q + AW'(1);
      end
      rv_q <= cmd_i.scan_issue;
      if (rv_q && is_rng) begin
        acc_q <= acc_nx;
      end
      if (cmd_i.count_inc) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.count_dec) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (cmd_i.div_init) begin
        rem_q  <= '0;
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        rem_q  <= rem_nx;
        dcnt_q <= dcnt_q + DCW'(1);
      end
      if (cmd_i.result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.req_type   = type_q;
  assign sts_o.err        = err_c;
  assign sts_o.need_shift = shift_c;
  assign sts_o.scan_last  = (idx_q == stop_q);
  assign sts_o.div_last   = (dcnt_q == DCW'(ACC_W - 1));
  assign sts_o.sum_mode   = op_mode_q;
  assign sts_o.out_free   = !out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{(OUT_TDATA_W-VAL_W-CNT_OUT_W){1'b0}}, out_cnt_q, out_res_q};
  assign out_err_o   = out_err_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt32 <= cap32) else $error("element count above capacity");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.result |-> !out_valid_q) else $error("result word overwritten");
  a_div_sum_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> op_mode_q) else $error("modulo step in xor mode");
  a_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.put |-> !rv_q) else $error("put collides with shift write");
`endif

endmodule

// ----- design/rasq_ctrl.sv -----
module rasq_ctrl
  import rasq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  rasq_sts_t sts_i,
  output rasq_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_PUT   = 3'd4;
  localparam logic [2:0] ST_DIVLD = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.err) begin
          state_d = ST_DONE;
        end else begin
          case (sts_i.req_type)
            REQ_INSERT: begin
              if (sts_i.need_shift) begin
                cmd_o.scan_init = 1'b1;
                state_d         = ST_SCAN;
              end else begin
                state_d = ST_PUT;
              end
            end
            REQ_ERASE: begin
              if (sts_i.need_shift) begin
                cmd_o.scan_init = 1'b1;
                state_d         = ST_SCAN;
              end else begin
                cmd_o.count_dec = 1'b1;
                state_d         = ST_DONE;
              end
            end
            REQ_CHANGE: state_d = ST_PUT;
            REQ_READ,
            REQ_RANGE: begin
              cmd_o.scan_init = 1'b1;
              state_d         = ST_SCAN;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        case (sts_i.req_type)
          REQ_INSERT: state_d = ST_PUT;
          REQ_ERASE: begin
            cmd_o.count_dec = 1'b1;
            state_d         = ST_DONE;
          end
          REQ_RANGE: state_d = sts_i.sum_mode ? ST_DIVLD : ST_DONE;
          default:   state_d = ST_DONE;
        endcase
      end
      ST_PUT: begin
        cmd_o.put       = 1'b1;
        cmd_o.count_inc = (sts_i.req_type == REQ_INSERT);
        state_d         = ST_DONE;
      end
      ST_DIVLD: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.result = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/range_aggregate_sequence_store_core.sv -----
// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid/tready       tdata: req_type, position, range_end, value
// m_axis    out        m_axis_tvalid/tready       tdata: result_value, element_count; tuser: error
// cfg       in         cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i (0 op_mode, 1 modulus)
//
// Insert and erase shift the elements between the position and the end, one memory move a
// cycle through the element RAM (one read and one write port). A range scans its elements
// and, in sum mode, adds a bit-serial modulo reduction; a full-length sum range is the
// worst case.
// Reset clears the count and configuration at once; no clearing pass is run.
// A finished result sits in the output register while the next word is taken in; a result
// waits in the controller while the output register is still full.
module range_aggregate_sequence_store_core
  import rasq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [2:0] req_type, [13:3] position, [24:14] range_end, [56:25] value
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [31:0] result_value, [42:32] element_count
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] error
  output logic                   m_axis_tuser
);

  rasq_cmd_t cmd;
  rasq_sts_t sts;

  // config is to be written only while idle (a rule for the user, not enforced here), so always take it
  assign cfg_ready_o = 1'b1;

  rasq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rasq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_err_o   (m_axis_tuser)
  );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import rasq_pkg::*;

  localparam int unsigned CLK_HALF   = 6;
  localparam int unsigned CYCLE_CAP  = 6000000;
  localparam int unsigned TAIL_WAIT  = 1200;
  localparam logic [TYPE_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [VAL_W-1:0]     value;
    logic [CNT_OUT_W-1:0] count;
    logic                 err;
  } outcome_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [2:0] req_type, [13:3] position, [24:14] range_end, [56:25] value
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [31:0] result_value, [42:32] element_count
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // [0] error
  logic                   m_axis_tuser;

  // Mirror of the store: the sequence itself plus the aggregate settings.
  logic [VAL_W-1:0] seq_elems[$];
  logic             sum_mode = 1'b0;
  logic [MOD_W-1:0] mod_reg = 31'd1;

  outcome_t    pending_results[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;

  range_aggregate_sequence_store_core dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Watchdog: any hang ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Randomly stall the result side, except during calm stretches.
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 9);
  end

  // Compare each accepted result word against the oldest expectation.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result value=%h count=%0d err=%b", $time,
                 m_axis_tdata[31:0], m_axis_tdata[42:32], m_axis_tuser);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (m_axis_tdata[31:0] !== want.value) begin
          mismatches++;
          $display("%0t: result_value expected %h actual %h", $time, want.value,
                   m_axis_tdata[31:0]);
        end
        if (m_axis_tdata[42:32] !== want.count) begin
          mismatches++;
          $display("%0t: element_count expected %0d actual %0d", $time, want.count,
                   m_axis_tdata[42:32]);
        end
        if (m_axis_tuser !== want.err) begin
          mismatches++;
          $display("%0t: error expected %b actual %b", $time, want.err, m_axis_tuser);
        end
      end
    end
  end

  function automatic longint unsigned eff_modulus();
    return (mod_reg == '0) ? 64'd1 : 64'(mod_reg);
  endfunction

  // Signed element reduced into 0..modulus-1.
  function automatic longint unsigned residue_of(logic [VAL_W-1:0] v);
    longint m;
    longint r;
    m = longint'(eff_modulus());
    r = longint'($signed(v)) % m;
    if (r < 0) r += m;
    return $unsigned(r);
  endfunction

  function automatic logic [VAL_W-1:0] range_fold(int unsigned lo, int unsigned hi);
    longint unsigned acc;
    acc = 0;
    for (int unsigned i = lo - 1; i < hi; i++) begin
      if (sum_mode) acc = (acc + residue_of(seq_elems[i])) % eff_modulus();
      else acc = acc ^ 64'(seq_elems[i]);
    end
    return acc[VAL_W-1:0];
  endfunction

  // Apply one request to the mirror and return the word it must produce.
  function automatic outcome_t apply_request(logic [TYPE_W-1:0] kind,
                                             logic [POS_W-1:0] pos,
                                             logic [POS_W-1:0] rend,
                                             logic [VAL_W-1:0] val);
    outcome_t o;
    int unsigned n;
    n = seq_elems.size();
    o = '0;
    case (kind)
      REQ_INSERT: begin
        if (n >= CAPACITY_DEF || pos < 1 || pos > n + 1) o.err = 1'b1;
        else seq_elems.insert(pos - 1, val);
      end
      REQ_ERASE: begin
        if (pos < 1 || pos > n) o.err = 1'b1;
        else seq_elems.delete(pos - 1);
      end
      REQ_CHANGE: begin
        if (pos < 1 || pos > n) o.err = 1'b1;
        else seq_elems[pos - 1] = val;
      end
      REQ_READ: begin
        if (pos < 1 || pos > n) o.err = 1'b1;
        else o.value = seq_elems[pos - 1];
      end
      REQ_RANGE: begin
        if (pos < 1 || rend < pos || rend > n) o.err = 1'b1;
        else o.value = range_fold(pos, rend);
      end
      default: ;  // unused codes only report the count
    endcase
    o.count = CNT_OUT_W'(seq_elems.size());
    return o;
  endfunction

  // Send one request word; record its expectation when it is taken.
  task automatic send_request(logic [TYPE_W-1:0] kind, logic [POS_W-1:0] pos,
                              logic [POS_W-1:0] rend, logic [VAL_W-1:0] val);
    outcome_t next_w;
    if (!calm && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, val, rend, pos, kind};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    next_w = apply_request(kind, pos, rend, val);
    pending_results.insert(pending_results.size(), next_w);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Write one register while the store is idle.
  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_OP_MODE) sum_mode = data[0];
    else if (idx == REG_MODULUS) mod_reg = data[MOD_W-1:0];
  endtask

  // One mostly well-formed request, with some noise mixed in.
  task automatic send_random_request(int unsigned max_len);
    int unsigned n;
    int unsigned pick;
    logic [POS_W-1:0] lo;
    n = seq_elems.size();
    pick = $urandom_range(99);
    if (pick < 30 || n == 0) begin
      if (n < max_len) begin
        send_request(REQ_INSERT, POS_W'($urandom_range(1, n + 1)), POS_W'($urandom),
                     $urandom);
      end else begin
        send_request(REQ_ERASE, POS_W'($urandom_range(1, n)), POS_W'($urandom), $urandom);
      end
    end else if (pick < 48) begin
      send_request(REQ_ERASE, POS_W'($urandom_range(1, n)), POS_W'($urandom), $urandom);
    end else if (pick < 60) begin
      send_request(REQ_CHANGE, POS_W'($urandom_range(1, n)), POS_W'($urandom), $urandom);
    end else if (pick < 74) begin
      send_request(REQ_READ, POS_W'($urandom_range(1, n)), POS_W'($urandom), $urandom);
    end else if (pick < 90) begin
      lo = POS_W'($urandom_range(1, n));
      send_request(REQ_RANGE, lo, POS_W'($urandom_range(lo, n)), $urandom);
    end else begin
      send_request(TYPE_W'($urandom_range(7)), POS_W'($urandom_range(2047)),
                   POS_W'($urandom_range(2047)), $urandom);
    end
  endtask

  task automatic test_directed();
    // Everything on an empty store is rejected.
    send_request(REQ_READ, 11'd1, 11'd0, '0);
    send_request(REQ_ERASE, 11'd1, 11'd0, '0);
    send_request(REQ_CHANGE, 11'd1, 11'd0, 32'h1);
    send_request(REQ_RANGE, 11'd1, 11'd1, '0);
    send_request(REQ_INSERT, 11'd0, 11'd0, 32'h5);
    send_request(REQ_INSERT, 11'd2, 11'd0, 32'h5);
    // Build a small sequence with extreme values, inserting at front and end.
    send_request(REQ_INSERT, 11'd1, 11'd0, 32'h8000_0000);
    send_request(REQ_INSERT, 11'd2, 11'd0, 32'h7FFF_FFFF);
    send_request(REQ_INSERT, 11'd1, 11'd0, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 11'd4, 11'd0, 32'h0);
    send_request(REQ_READ, 11'd3, 11'd0, '0);
    send_request(REQ_CHANGE, 11'd2, 11'd0, 32'h1234_5678);
    send_request(REQ_RANGE, 11'd1, 11'd4, '0);
    send_request(REQ_RANGE, 11'd3, 11'd2, '0);
    send_request(REQ_RANGE, 11'd1, 11'd5, '0);
    send_request(REQ_READ, 11'd5, 11'd0, '0);
    send_request(REQ_INSERT, 11'd2047, 11'd2047, 32'hA5A5_5A5A);
    for (logic [TYPE_W-1:0] k = REQ_UNUSED_LO; k <= REQ_UNUSED_HI && k != 3'd0; k++)
      send_request(k, 11'd1, 11'd1, 32'hFFFF_FFFF);
    send_request(REQ_ERASE, 11'd4, 11'd0, '0);
    send_request(REQ_ERASE, 11'd1, 11'd0, '0);
    send_request(REQ_RANGE, 11'd1, 11'd2, '0);
  endtask

  // Sum with a zero modulus acts as modulus one.
  task automatic test_zero_modulus();
    write_setting(REG_MODULUS, 32'h0);
    write_setting(REG_OP_MODE, 32'h1);
    send_request(REQ_RANGE, 11'd1, 11'd2, '0);
    send_request(REQ_READ, 11'd2, 11'd0, '0);
  endtask

  // Fill to capacity, reject two inserts, then ranges, a read, a change, front erases around an xor range.
  task automatic test_full_store();
    write_setting(REG_MODULUS, 32'hFFFF_FFFF);
    write_setting(REG_OP_MODE, 32'h1);
    while (seq_elems.size() < CAPACITY_DEF)
      send_request(REQ_INSERT, POS_W'(seq_elems.size() + 1), '0, $urandom);
    send_request(REQ_INSERT, 11'd1, '0, 32'h7);
    send_request(REQ_INSERT, 11'd1025, '0, 32'h7);
    send_request(REQ_RANGE, 11'd1, 11'd1024, '0);
    send_request(REQ_RANGE, 11'd33, 11'd1000, '0);
    send_request(REQ_READ, 11'd1024, '0, '0);
    send_request(REQ_CHANGE, 11'd1024, '0, 32'h8000_0000);
    send_request(REQ_ERASE, 11'd1, '0, '0);
    write_setting(REG_OP_MODE, 32'h0);
    send_request(REQ_RANGE, 11'd1, 11'd1023, '0);
    send_request(REQ_ERASE, 11'd1, '0, '0);
  endtask

  // Random phases, each under a different setting, extremes included.
  task automatic test_random();
    logic [CFG_DATA_W-1:0] modes[6] = '{32'h0, 32'h1, 32'h1, 32'hFFFF_FFFE, 32'h1, 32'h1};
    logic [CFG_DATA_W-1:0] mods[6]  = '{32'h3, 32'h1, 32'h7FFF_FFFF, 32'h5, 32'h7, 32'h0};
    for (int p = 0; p < 6; p++) begin
      write_setting(REG_MODULUS, (p == 5) ? $urandom : mods[p]);
      write_setting(REG_OP_MODE, modes[p]);
      for (int i = 0; i < 40; i++) begin
        calm = (p == 2 && i >= 10 && i < 35);
        send_random_request(p == 4 ? 200 : 70);
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    int unsigned waited;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_zero_modulus();
    test_full_store();
    test_random();
    drain_results();
    waited = 0;
    while (waited < TAIL_WAIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/rasq_pkg.sv
design/rasq_datapath.sv
design/rasq_ctrl.sv
design/range_aggregate_sequence_store_core.sv
sim/testbench.sv
